// File: hw/rtl/dns_name_decoder_assert.svh
// Assertion macros shared by the checkers of the DNS name decoder.
// Every macro samples on clk; the checker that expands it supplies clk and arst_n.
`ifndef DNS_NAME_DECODER_ASSERT_SVH
`define DNS_NAME_DECODER_ASSERT_SVH

// Property checked outside reset only.
`define DND_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define DND_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/dnd_pkg.sv
// Shared constants, state encoding and controller/datapath interface types
// for the DNS name decoder. No dependencies.
package dnd_pkg;

	localparam int MSG_BYTES   = 512;
	localparam int MSG_AW      = $clog2(MSG_BYTES);
	localparam int POS_W       = 9;
	localparam int LEN_W       = 10;
	localparam int WPOS_W      = 10;
	localparam int TGT_W       = 14;
	localparam int CHUNK_CHARS = 8;
	localparam int CHUNK_IW    = $clog2(CHUNK_CHARS);
	localparam int CNT_W       = 4;
	localparam int MAX_CHUNKS  = 64;
	localparam int CHUNK_NW    = $clog2(MAX_CHUNKS);
	localparam int WIRE_W      = 10;

	localparam logic [7:0] PTR_TAG       = 8'hC0;
	localparam logic [7:0] PTR_HIGH_MASK = 8'h3F;
	localparam logic [7:0] DOT_CHAR      = 8'h2E;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TL_RD,
		ST_TL_EV,
		ST_NW_RD,
		ST_NW_EV,
		ST_NW_PRD,
		ST_NW_PEV,
		ST_NW_PDOT,
		ST_NW_DOT,
		ST_NW_CRD,
		ST_NW_CEV,
		ST_FIN
	} dnd_state_t;

	typedef struct packed {
		logic start;
		logic wr;
		logic rd_top;
		logic rd_walk;
		logic tl_step;
		logic nw_label;
		logic ptr_take;
		logic put_dot;
		logic put_chr;
		logic te_set;
		logic te_clr;
		logic fin;
	} dnd_cmd_t;

	typedef struct packed {
		logic p_lt_len;
		logic w_lt_len;
		logic byte_zero;
		logic byte_tag;
		logic lab_over;
		logic tgt_ok;
		logic can_put;
		logic out_free;
		logic rem_last;
		logic te;
	} dnd_status_t;

endpackage

// File: hw/rtl/dnd_ctrl.sv
// Controller state machine of the DNS name decoder.
// Depends on dnd_pkg; drives dnd_datapath through dnd_cmd_t.
module dnd_ctrl import dnd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        mode,
	input  dnd_status_t status,
	output logic        busy,
	output dnd_cmd_t    cmd
);

	dnd_state_t state_q;
	dnd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && mode == MODE_DECODE) state_d = ST_TL_RD;
			end
			ST_TL_RD:  state_d = status.p_lt_len ? ST_TL_EV : ST_NW_RD;
			ST_TL_EV:  state_d = (status.byte_zero || status.byte_tag) ? ST_NW_RD : ST_TL_RD;
			ST_NW_RD:  state_d = status.w_lt_len ? ST_NW_EV : ST_FIN;
			ST_NW_EV: begin
				if (status.byte_zero)     state_d = ST_FIN;
				else if (status.byte_tag) state_d = ST_NW_PRD;
				else if (status.lab_over) state_d = ST_FIN;
				else if (status.te)       state_d = ST_NW_DOT;
				else                      state_d = ST_NW_CRD;
			end
			ST_NW_PRD: state_d = status.w_lt_len ? ST_NW_PEV : ST_FIN;
			ST_NW_PEV: begin
				if (!status.tgt_ok)  state_d = ST_FIN;
				else if (status.te)  state_d = ST_NW_PDOT;
				else                 state_d = ST_NW_RD;
			end
			ST_NW_PDOT: begin
				if (status.can_put) state_d = ST_NW_RD;
			end
			ST_NW_DOT: begin
				if (status.can_put) state_d = ST_NW_CRD;
			end
			ST_NW_CRD: state_d = ST_NW_CEV;
			ST_NW_CEV: begin
				if (status.can_put) state_d = status.rem_last ? ST_NW_RD : ST_NW_CRD;
			end
			ST_FIN: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.start = cmd_valid && mode == MODE_DECODE;
				cmd.wr    = cmd_valid && mode == MODE_WRITE;
			end
			ST_TL_RD:   cmd.rd_top   = status.p_lt_len;
			ST_TL_EV:   cmd.tl_step  = 1'b1;
			ST_NW_RD:   cmd.rd_walk  = status.w_lt_len;
			ST_NW_EV:   cmd.nw_label = 1'b1;
			ST_NW_PRD:  cmd.rd_walk  = status.w_lt_len;
			ST_NW_PEV:  cmd.ptr_take = status.tgt_ok;
			ST_NW_PDOT: begin
				cmd.put_dot = 1'b1;
				cmd.te_clr  = status.can_put;
			end
			ST_NW_DOT:  cmd.put_dot  = 1'b1;
			ST_NW_CRD:  cmd.rd_walk  = 1'b1;
			ST_NW_CEV: begin
				cmd.put_chr = 1'b1;
				cmd.te_set  = status.can_put && status.rem_last;
			end
			ST_FIN:     cmd.fin      = 1'b1;
			default:    cmd          = '0;
		endcase
	end

endmodule

// File: hw/rtl/dnd_datapath.sv
// Datapath of the DNS name decoder: message store, walk registers, chunk
// assembly and result register. Depends on dnd_pkg; commanded by dnd_ctrl.
module dnd_datapath import dnd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dnd_cmd_t                 cmd,
	output dnd_status_t              status,
	input  logic [7:0]               byte_value,
	input  logic [POS_W-1:0]         position,
	input  logic [LEN_W-1:0]         message_length,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [CHUNK_CHARS*8-1:0] name_chars,
	output logic [CNT_W-1:0]         char_count,
	output logic                     last,
	output logic                     truncated,
	output logic [WIRE_W-1:0]        wire_length,
	output logic                     used_pointer
);

	logic [7:0]         mem_q [MSG_BYTES];
	logic [7:0]         rd_q;
	logic [MSG_AW-1:0]  rd_addr;

	logic [POS_W-1:0]   start_q;
	logic [LEN_W-1:0]   len_q;
	logic [WIRE_W-1:0]  p_q;
	logic               ptr_q;
	logic [WPOS_W-1:0]  wpos_q;
	logic [WPOS_W-1:0]  seg_q;
	logic               te_q;
	logic [7:0]         lab_q;
	logic [7:0]         rem_q;

	logic [7:0]         buf_q [CHUNK_CHARS];
	logic [CHUNK_CHARS*8-1:0] buf_flat;
	logic [CNT_W-1:0]   cnt_q;
	logic [CHUNK_NW-1:0] chunks_q;
	logic               cut_q;

	logic               res_valid_q;
	logic [CHUNK_CHARS*8-1:0] res_chars_q;
	logic [CNT_W-1:0]   res_count_q;
	logic               res_last_q;
	logic               res_trunc_q;
	logic [WIRE_W-1:0]  res_wire_q;
	logic               res_ptr_q;

	logic [LEN_W-1:0]   len_clamp;
	logic [TGT_W-1:0]   tgt;
	logic               buf_full;
	logic               at_cap;
	logic               out_free;
	logic               can_put;
	logic               put_ok;
	logic [7:0]         put_char;
	logic               wr_in_range;

	assign len_clamp = (int'(message_length) > MSG_BYTES) ? LEN_W'(MSG_BYTES) : message_length;
	assign rd_addr   = cmd.rd_top ? p_q[MSG_AW-1:0] : wpos_q[MSG_AW-1:0];
	assign tgt       = {lab_q[5:0] & PTR_HIGH_MASK[5:0], rd_q};
	assign wr_in_range = int'(position) < MSG_BYTES;

	assign buf_full = cnt_q == CNT_W'(CHUNK_CHARS);
	assign at_cap   = buf_full && chunks_q == CHUNK_NW'(MAX_CHUNKS - 1);
	assign out_free = !res_valid_q || !res_stall;
	assign can_put  = !(buf_full && !at_cap) || out_free;
	assign put_ok   = (cmd.put_dot || cmd.put_chr) && can_put;
	assign put_char = cmd.put_dot ? DOT_CHAR : rd_q;

	always_comb begin
		for (int i = 0; i < CHUNK_CHARS; i++) begin
			buf_flat[i*8 +: 8] = buf_q[i];
		end
	end

	assign status.p_lt_len  = p_q < WIRE_W'(len_q);
	assign status.w_lt_len  = wpos_q < WPOS_W'(len_q);
	assign status.byte_zero = rd_q == 8'd0;
	assign status.byte_tag  = (rd_q & PTR_TAG) == PTR_TAG;
	assign status.lab_over  = (11'(wpos_q) + 11'd1 + 11'(rd_q)) > 11'(len_q);
	assign status.tgt_ok    = tgt < TGT_W'(seg_q);
	assign status.can_put   = can_put;
	assign status.out_free  = out_free;
	assign status.rem_last  = rem_q == 8'd1;
	assign status.te        = te_q;

	// Message store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr && wr_in_range) begin
			mem_q[MSG_AW'(position)] <= byte_value;
		end
		if (cmd.rd_top || cmd.rd_walk) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			chunks_q    <= '0;
			cut_q       <= 1'b0;
			te_q        <= 1'b0;
			wpos_q      <= '0;
			seg_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			if (cmd.start) begin
				cnt_q    <= '0;
				chunks_q <= '0;
				cut_q    <= 1'b0;
				te_q     <= 1'b0;
				wpos_q   <= WPOS_W'(position);
				seg_q    <= WPOS_W'(position);
			end
			if (cmd.nw_label) wpos_q <= wpos_q + 1'b1;
			if (cmd.ptr_take) begin
				seg_q  <= WPOS_W'(tgt);
				wpos_q <= WPOS_W'(tgt);
			end
			if (cmd.te_set) te_q <= 1'b1;
			if (cmd.te_clr) te_q <= 1'b0;
			if (cmd.put_chr && can_put) wpos_q <= wpos_q + 1'b1;
			if (put_ok) begin
				if (buf_full) begin
					if (at_cap) begin
						cut_q <= 1'b1;
					end else begin
						res_valid_q <= 1'b1;
						chunks_q    <= chunks_q + 1'b1;
						cnt_q       <= CNT_W'(1);
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.fin && out_free) res_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			start_q <= position;
			len_q   <= len_clamp;
			p_q     <= WIRE_W'(position);
			ptr_q   <= 1'b0;
			for (int i = 0; i < CHUNK_CHARS; i++) buf_q[i] <= 8'd0;
		end
		if (cmd.tl_step) begin
			if (status.byte_zero)     p_q <= p_q + 1'b1;
			else if (status.byte_tag) p_q <= p_q + WIRE_W'(2);
			else                      p_q <= p_q + WIRE_W'(rd_q) + 1'b1;
			ptr_q <= ptr_q | status.byte_tag;
		end
		if (cmd.nw_label) begin
			lab_q <= rd_q;
			rem_q <= rd_q;
		end
		if (cmd.put_chr && can_put) rem_q <= rem_q - 1'b1;
		if (put_ok) begin
			if (buf_full) begin
				if (!at_cap) begin
					res_chars_q <= buf_flat;
					res_count_q <= cnt_q;
					res_last_q  <= 1'b0;
					res_trunc_q <= 1'b0;
					res_wire_q  <= '0;
					res_ptr_q   <= 1'b0;
					for (int i = 1; i < CHUNK_CHARS; i++) buf_q[i] <= 8'd0;
					buf_q[0] <= put_char;
				end
			end else begin
				buf_q[cnt_q[CHUNK_IW-1:0]] <= put_char;
			end
		end
		if (cmd.fin && out_free) begin
			res_chars_q <= buf_flat;
			res_count_q <= cnt_q;
			res_last_q  <= 1'b1;
			res_trunc_q <= cut_q;
			res_wire_q  <= p_q - WIRE_W'(start_q);
			res_ptr_q   <= ptr_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign name_chars   = res_chars_q;
	assign char_count   = res_count_q;
	assign last         = res_last_q;
	assign truncated    = res_trunc_q;
	assign wire_length  = res_wire_q;
	assign used_pointer = res_ptr_q;

endmodule

// File: hw/rtl/dns_name_decoder.sv
// A decode reads and evaluates each top-level label or pointer, then each name-walk label
// byte or pointer byte, then each character, and ends with a closing transfer.
// Throughput: one item at a time; the single store read port sets the pace.
// Reset (arst_n low, asynchronous): controller to idle, result register empty, walk
// state cleared; the message store is not cleared and holds garbage until written.
// Top level of the DNS name decoder; depends on dnd_pkg, dnd_ctrl and dnd_datapath.
module dns_name_decoder import dnd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Request channel: message byte writes and decode requests
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic                     mode,
	input  logic [7:0]               byte_value,
	input  logic [POS_W-1:0]         position,
	input  logic [LEN_W-1:0]         message_length,
	// Result channel: one transfer per chunk of decoded text
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [CHUNK_CHARS*8-1:0] name_chars,
	output logic [CNT_W-1:0]         char_count,
	output logic                     last,
	output logic                     truncated,
	output logic [WIRE_W-1:0]        wire_length,
	output logic                     used_pointer
);

	dnd_cmd_t    cmd;
	dnd_status_t status;
	logic        busy;

	// Hold off new requests while a decode walks the store; a finished chunk
	// waiting in the result register does not block the request side.
	assign cmd_stall = busy;

	// Controller: top-level walk first (wire length, pointer flag), then the
	// name walk that emits characters, then the closing transfer.
	dnd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.mode      (mode),
		.status    (status),
		.busy      (busy),
		.cmd       (cmd)
	);

	// Datapath: store, walk pointers, chunk assembly and result register.
	dnd_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.byte_value     (byte_value),
		.position       (position),
		.message_length (message_length),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.name_chars     (name_chars),
		.char_count     (char_count),
		.last           (last),
		.truncated      (truncated),
		.wire_length    (wire_length),
		.used_pointer   (used_pointer)
	);

endmodule

// File: hw/rtl/dnd_checker.sv
// Port-level checker for the DNS name decoder, bound to the top level.
// Depends on dnd_pkg and dns_name_decoder_assert.svh.
`include "dns_name_decoder_assert.svh"

module dnd_checker import dnd_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cmd_valid,
	input logic                     cmd_stall,
	input logic                     mode,
	input logic                     res_valid,
	input logic                     res_stall,
	input logic [CHUNK_CHARS*8-1:0] name_chars,
	input logic [CNT_W-1:0]         char_count,
	input logic                     last,
	input logic                     truncated,
	input logic [WIRE_W-1:0]        wire_length,
	input logic                     used_pointer
);

	`DND_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(name_chars), "stalled result dropped or changed")
	`DND_ASSERT(a_mid_chunk_full, res_valid && !last |-> char_count == CNT_W'(CHUNK_CHARS) && !truncated && wire_length == '0 && !used_pointer, "non-final chunk malformed")
	`DND_ASSERT(a_count_range, res_valid |-> char_count <= CNT_W'(CHUNK_CHARS), "chunk count out of range")
	`DND_ASSERT(a_write_one_cycle, cmd_valid && !cmd_stall && mode == MODE_WRITE |=> !cmd_stall, "byte write left the block busy")
	`DND_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !res_valid && !cmd_stall, "outputs active during reset")

endmodule

bind dns_name_decoder dnd_checker u_checker (.*);

// File: bench/tb_dns_name_decoder.sv
// Self-checking testbench for dns_name_decoder: loads messages, requests decodes and
// checks every chunk against a behavioural walk of the same message.
// Depends on dnd_pkg and the dns_name_decoder RTL only.
module tb_dns_name_decoder;
	import dnd_pkg::*;

	localparam int RANDOM_ITEMS = 350;
	localparam int IDLE_PERCENT = 6;
	localparam int DRAIN_CYCLES = 200;
	localparam int REPORT_LIMIT = 100;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int TEXT_CAP     = MAX_CHUNKS * CHUNK_CHARS;

	// One result transfer: a chunk of decoded text plus the closing flags
	typedef struct {
		logic [CHUNK_CHARS*8-1:0] chars;
		logic [CNT_W-1:0]         count;
		logic                     fin;
		logic                     cut;
		logic [WIRE_W-1:0]        wire_len;
		logic                     ptr;
	} chunk_t;

	logic                     clk;
	logic                     arst_n         = 1'b0;
	logic                     cmd_valid      = 1'b0;
	logic                     cmd_stall;
	logic                     mode           = MODE_WRITE;
	logic [7:0]               byte_value     = 8'h00;
	logic [POS_W-1:0]         position       = '0;
	logic [LEN_W-1:0]         message_length = '0;
	logic                     res_valid;
	logic                     res_stall      = 1'b0;
	logic [CHUNK_CHARS*8-1:0] name_chars;
	logic [CNT_W-1:0]         char_count;
	logic                     last;
	logic                     truncated;
	logic [WIRE_W-1:0]        wire_length;
	logic                     used_pointer;

	// Shadow of the message store and the chunks still owed by the block
	logic [7:0] message_copy [0:MSG_BYTES-1];
	chunk_t     chunks_due [$];
	// Bytes of the message being built by the current test
	logic [7:0] msg_bytes [$];

	bit idle_enable  = 1'b1;
	bit stall_enable = 1'b1;
	int items_sent;
	int writes_sent;
	int decodes_sent;
	int chunks_checked;
	int cut_decodes;
	int faults;

	dns_name_decoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.mode           (mode),
		.byte_value     (byte_value),
		.position       (position),
		.message_length (message_length),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.name_chars     (name_chars),
		.char_count     (char_count),
		.last           (last),
		.truncated      (truncated),
		.wire_length    (wire_length),
		.used_pointer   (used_pointer)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Walk the shadow store as the block should and queue the chunks it owes.
	// All text is gathered first and cut at the cap afterwards: dropping every
	// character past the cap is the same as never storing it.
	function automatic void decode_to_chunks(input int start, input int req_len);
		int         len;
		int         walk;
		int         seg;
		int         tgt;
		int         p;
		int         wire_len;
		int         n_chunks;
		int         cnt;
		bit         emitted;
		bit         done;
		bit         cut;
		bit         ptr_seen;
		logic [7:0] lab;
		logic [7:0] text [$];
		chunk_t     c;

		len = (req_len > MSG_BYTES) ? MSG_BYTES : req_len;

		// Name walk: follow labels, take only pointers that go strictly backwards
		walk = start;
		seg = start;
		emitted = 1'b0;
		done = 1'b0;
		while (!done && walk < len) begin
			lab = message_copy[walk];
			walk++;
			if (lab == 8'h00) begin
				done = 1'b1;
			end else if ((lab & PTR_TAG) == PTR_TAG) begin
				if (walk >= len) begin
					done = 1'b1;
				end else begin
					tgt = {lab & PTR_HIGH_MASK, message_copy[walk]};
					if (tgt >= seg) begin
						done = 1'b1;
					end else begin
						if (emitted)
							text.push_back(DOT_CHAR);
						seg = tgt;
						walk = tgt;
						emitted = 1'b0;
					end
				end
			end else if (walk + lab > len) begin
				done = 1'b1;
			end else begin
				if (emitted)
					text.push_back(DOT_CHAR);
				for (int i = 0; i < lab; i++)
					text.push_back(message_copy[walk + i]);
				walk += lab;
				emitted = 1'b1;
			end
		end
		cut = text.size() > TEXT_CAP;
		while (text.size() > TEXT_CAP)
			void'(text.pop_back());

		// Top-level length: no bounds checks on labels, pointer ends the name
		p = start;
		ptr_seen = 1'b0;
		done = 1'b0;
		while (!done && p < len) begin
			lab = message_copy[p];
			p++;
			if (lab == 8'h00) begin
				done = 1'b1;
			end else if ((lab & PTR_TAG) == PTR_TAG) begin
				p++;
				ptr_seen = 1'b1;
				done = 1'b1;
			end else begin
				p += lab;
			end
		end
		wire_len = (p >= start) ? p - start : 0;

		n_chunks = (text.size() + CHUNK_CHARS - 1) / CHUNK_CHARS;
		if (n_chunks == 0)
			n_chunks = 1;
		for (int k = 0; k < n_chunks; k++) begin
			cnt = text.size() - k * CHUNK_CHARS;
			if (cnt < 0)
				cnt = 0;
			if (cnt > CHUNK_CHARS)
				cnt = CHUNK_CHARS;
			c.chars = '0;
			for (int i = 0; i < cnt; i++)
				c.chars[8*i +: 8] = text[k * CHUNK_CHARS + i];
			c.count = cnt;
			c.fin = (k == n_chunks - 1);
			c.cut = c.fin && cut;
			c.wire_len = c.fin ? wire_len : 0;
			c.ptr = c.fin && ptr_seen;
			chunks_due.push_back(c);
		end
		if (cut)
			cut_decodes++;
	endfunction

	// Offer one request, hold it through any stall, update the shadow on transfer
	task automatic send_item(input logic m, input logic [7:0] b, input logic [POS_W-1:0] pos,
			input logic [LEN_W-1:0] len);
		while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		mode <= m;
		byte_value <= b;
		position <= pos;
		message_length <= len;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		items_sent++;
		if (m == MODE_WRITE) begin
			message_copy[pos] = b;
			writes_sent++;
		end else begin
			decode_to_chunks(pos, len);
			decodes_sent++;
		end
	endtask

	task automatic load_message(input int base);
		foreach (msg_bytes[i])
			send_item(MODE_WRITE, msg_bytes[i], base + i, '0);
	endtask

	function automatic void add_label(input string s);
		msg_bytes.push_back(s.len());
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endfunction

	// Fill the whole store with single-character labels ending in a pointer back
	// into the run. A decode from just above the target reads the run twice and
	// overflows the chunk limit; the fill also leaves no entry unwritten.
	task automatic test_truncation();
		msg_bytes.delete();
		for (int a = 0; a < MSG_BYTES; a++) begin
			if (a < 508)
				msg_bytes.push_back(8'h01);
			else if (a == 508)
				msg_bytes.push_back(PTR_TAG);
			else if (a == 509)
				msg_bytes.push_back(8'd192);
			else if (a == 510)
				msg_bytes.push_back(8'h00);
			else
				msg_bytes.push_back(8'hFF);
		end
		load_message(0);
		send_item(MODE_DECODE, 8'h00, 9'd194, 10'd512);
		// Pointer to its own segment start: one pass only, long but not cut
		send_item(MODE_DECODE, 8'hFF, 9'd192, 10'd1023);
	endtask

	// Hand-built names covering each way a walk ends
	task automatic test_directed();
		msg_bytes.delete();
		add_label("www");
		add_label("example");
		add_label("com");
		msg_bytes.push_back(8'h00);           // end of name at 16
		add_label("mail");                    // 17: label then pointer back to 4
		msg_bytes.push_back(PTR_TAG);
		msg_bytes.push_back(8'd4);
		msg_bytes.push_back(PTR_TAG);         // 24: pointer to itself
		msg_bytes.push_back(8'd24);
		add_label("ab");                      // 26: label then forward pointer
		msg_bytes.push_back(PTR_TAG);
		msg_bytes.push_back(8'd30);
		msg_bytes.push_back(8'h3F);           // 31: longest label
		load_message(0);

		send_item(MODE_DECODE, 8'h00, 9'd0, 10'd40);    // plain name
		send_item(MODE_DECODE, 8'h00, 9'd17, 10'd40);   // backward pointer, full chunks
		send_item(MODE_DECODE, 8'h00, 9'd24, 10'd40);   // self pointer
		send_item(MODE_DECODE, 8'h00, 9'd26, 10'd40);   // forward pointer after text
		send_item(MODE_DECODE, 8'h00, 9'd31, 10'd40);   // label overruns the message
		send_item(MODE_DECODE, 8'h00, 9'd16, 10'd40);   // empty name
		send_item(MODE_DECODE, 8'h00, 9'd22, 10'd23);   // pointer byte missing
		send_item(MODE_DECODE, 8'h00, 9'd5, 10'd0);     // zero message length
		send_item(MODE_DECODE, 8'h00, 9'd0, 10'd1023);  // length clamped to the store
		send_item(MODE_DECODE, 8'h00, 9'd0, 10'd10);    // cut mid-name
		send_item(MODE_DECODE, 8'h00, 9'd31, 10'd512);  // longest label, then the run
		send_item(MODE_DECODE, 8'h00, 9'd511, 10'd512); // pointer in the last byte
		send_item(MODE_DECODE, 8'h00, 9'd510, 10'd1023);
	endtask

	// Rounds of well-formed names with random content, some broken pointers,
	// stray writes and decodes from random places. Every fourth round runs
	// with no idling on either side.
	task automatic test_random_names();
		int         goal;
		int         round;
		int         base;
		int         top;
		int         n_names;
		int         n_labels;
		int         lab_len;
		int         choice;
		int         len;
		int         n;
		int         l;
		int         c;
		int         starts [$];
		logic [7:0] rnd;
		logic [13:0] tgt;

		goal = items_sent + RANDOM_ITEMS;
		round = 0;
		while (items_sent < goal) begin
			idle_enable = (round % 4) != 2;
			stall_enable = idle_enable;
			msg_bytes.delete();
			starts.delete();
			base = $urandom_range(0, 250);
			n_names = $urandom_range(3, 6);
			for (n = 0; n < n_names && base + msg_bytes.size() < 300; n++) begin
				starts.push_back(base + msg_bytes.size());
				n_labels = $urandom_range(0, 3);
				for (l = 0; l < n_labels; l++) begin
					if ($urandom_range(0, 15) == 0)
						lab_len = $urandom_range(9, 63);
					else
						lab_len = $urandom_range(1, 8);
					msg_bytes.push_back(lab_len);
					for (c = 0; c < lab_len; c++) begin
						rnd = $urandom;
						msg_bytes.push_back(($urandom_range(0, 9) == 0) ? rnd : 8'd97 + rnd % 26);
					end
				end
				// Terminate with a zero, a pointer to an earlier name, or any pointer
				choice = $urandom_range(0, 9);
				if (choice < 6 || (n == 0 && choice < 9)) begin
					msg_bytes.push_back(8'h00);
				end else begin
					if (choice < 9)
						tgt = starts[$urandom_range(0, n - 1)];
					else
						tgt = $urandom;
					msg_bytes.push_back(PTR_TAG | tgt[13:8]);
					msg_bytes.push_back(tgt[7:0]);
				end
			end
			top = base + msg_bytes.size();
			load_message(base);
			if ($urandom_range(0, 2) == 0)
				send_item(MODE_WRITE, $urandom, $urandom_range(0, MSG_BYTES - 1), $urandom);
			foreach (starts[i]) begin
				choice = $urandom_range(0, 9);
				if (choice < 7)
					len = top;
				else if (choice < 9)
					len = $urandom_range(starts[i], top);
				else
					len = $urandom_range(MSG_BYTES, 1023);
				send_item(MODE_DECODE, $urandom, starts[i], len);
			end
			send_item(MODE_DECODE, $urandom, $urandom_range(0, MSG_BYTES - 1),
				$urandom_range(0, 1023));
			round++;
		end
		idle_enable = 1'b1;
		stall_enable = 1'b1;
	endtask

	// Check each result transfer against the oldest chunk owed, then pick the
	// stall for the next edge. Reads happen before the new stall takes effect.
	always @(posedge clk) begin : result_check
		chunk_t want;
		if (arst_n && res_valid && !res_stall) begin
			chunks_checked++;
			if (chunks_due.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("%0t: chunk with nothing due: chars=%h count=%0d last=%b",
						$time, name_chars, char_count, last);
			end else begin
				want = chunks_due.pop_front();
				if (want.chars !== name_chars || want.count !== char_count ||
						want.fin !== last || want.cut !== truncated ||
						want.wire_len !== wire_length || want.ptr !== used_pointer) begin
					faults++;
					if (faults <= REPORT_LIMIT)
						$display({"%0t: chunk mismatch: expected chars=%h count=%0d last=%b ",
							"truncated=%b wire_length=%0d used_pointer=%b, actual chars=%h ",
							"count=%0d last=%b truncated=%b wire_length=%0d used_pointer=%b"},
							$time, want.chars, want.count, want.fin, want.cut,
							want.wire_len, want.ptr, name_chars, char_count, last,
							truncated, wire_length, used_pointer);
				end
			end
		end
		res_stall <= stall_enable && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("%0t: run limit reached with %0d chunks still due", $time, chunks_due.size());
		$display("dns_name_decoder regression: fail");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_truncation();
		test_directed();
		test_random_names();
		cmd_valid <= 1'b0;

		// Drain: wait for every owed chunk, then watch for strays
		while (chunks_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d byte writes and %0d decodes; checked %0d chunks, %0d decodes cut at the limit.",
			writes_sent, decodes_sent, chunks_checked, cut_decodes);
		$display("Idle and stall gaps on both channels, one stretch in four without any; %0d faults.",
			faults);
		if (faults == 0)
			$display("dns_name_decoder regression: pass");
		else
			$display("dns_name_decoder regression: fail");
		$finish;
	end

endmodule
